// File: rtl/isv_pkg.sv
// ----------------------------------------------------------------------------
// isv_pkg: shared definitions for the indexed stack vector
// Operation and status codes, default sizes and the fixed field widths.
// ----------------------------------------------------------------------------
package isv_pkg;

  localparam int unsigned IsvDefaultCapacity  = 1024;
  localparam int unsigned IsvDefaultDataWidth = 32;

  localparam int unsigned FuncWidth     = 2;
  localparam int unsigned PositionWidth = 12;
  localparam int unsigned WordWidth     = 32;
  localparam int unsigned StatusWidth   = 2;
  localparam int unsigned LengthWidth   = 11;

  typedef enum logic [FuncWidth-1:0] {
    FUNC_GET  = 2'd0,
    FUNC_SET  = 2'd1,
    FUNC_PUSH = 2'd2,
    FUNC_POP  = 2'd3
  } func_e;

  typedef enum logic [StatusWidth-1:0] {
    STATUS_OK    = 2'd0,
    STATUS_RANGE = 2'd1,
    STATUS_FULL  = 2'd2
  } status_e;

endpackage

// File: rtl/indexed_stack_vector.sv
// ----------------------------------------------------------------------------
// indexed_stack_vector: bounded vector of signed words with a length
// Get, set, push and pop on a single-port synchronous memory plus a length
// register. Sets past the current length zero-fill the gap one word a cycle.
// ----------------------------------------------------------------------------
// Usage: the request channel (in_valid_i, in_stall_o) carries func_i,
// position_i and wdata_i. The result channel (out_valid_o, out_stall_i)
// carries status_o, rdata_o and length_o. An item moves on a rising edge
// with valid high and stall low. Every request gives exactly one result.
// A request is accepted in the idle state; its result is loaded into the
// output register from the response state before the next request is
// accepted, so the block takes no new request until it is through with the
// last. Get and pop use the memory's registered read. A set at position p
// with p at or past the length n writes n through p, filling the gap.
// The result sits in an output register, so a new request is accepted
// while the previous result still waits; if the receiver stalls, the next
// result is held inside and the request side stalls until it can leave.
// Reset empties the vector (length zero) and drops any pending result; the
// memory contents are not cleared.
// ----------------------------------------------------------------------------
module indexed_stack_vector
  import isv_pkg::*;
#(
  parameter int unsigned Capacity  = IsvDefaultCapacity,
  parameter int unsigned DataWidth = IsvDefaultDataWidth
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic [FuncWidth-1:0]            func_i,
  input  logic [PositionWidth-1:0]        position_i,
  input  logic signed [WordWidth-1:0]     wdata_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic [StatusWidth-1:0]          status_o,
  output logic signed [WordWidth-1:0]     rdata_o,
  output logic [LengthWidth-1:0]          length_o
);

  localparam int unsigned AW = $clog2(Capacity);
  localparam int unsigned CW = $clog2(Capacity + 1);
  localparam int unsigned XW = (CW > PositionWidth) ? CW : PositionWidth;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_FILL = 3'b010,
    ST_RESP = 3'b100
  } state_e;

  state_e                 state_q, state_d;
  logic [CW-1:0]          used_q, used_d;
  logic [AW-1:0]          fill_ptr_q, fill_ptr_d;
  logic [AW-1:0]          pos_q;
  logic [DataWidth-1:0]   wdata_q;
  status_e                res_status_q, res_status_d;
  logic                   res_use_mem_q, res_use_mem_d;

  logic [DataWidth-1:0]   store_q [Capacity];
  logic [DataWidth-1:0]   mem_rdata_q;
  logic                   mem_we;
  logic                   mem_re;
  logic [AW-1:0]          mem_addr;
  logic [DataWidth-1:0]   mem_wdata;

  logic                   out_valid_q;
  logic                   out_load;
  logic [StatusWidth-1:0] status_q;
  logic [WordWidth-1:0]   rdata_q;
  logic [LengthWidth-1:0] length_q;

  logic                        in_acc;
  logic [XW+PositionWidth-1:0] pos_ext;
  logic [XW+CW-1:0]            used_ext;
  logic [XW-1:0]               pos_x;
  logic [XW-1:0]               used_x;
  logic [XW-1:0]               cap_x;
  logic [DataWidth+WordWidth-1:0] wdata_ext;
  logic [DataWidth-1:0]        wdata_dw;
  logic [CW+AW-1:0]            pos_q_ext;
  logic [CW-1:0]               used_m1;
  logic [WordWidth+DataWidth-1:0] rdata_ext;
  logic [LengthWidth+CW-1:0]   len_ext;

  assign in_acc    = in_valid_i && !in_stall_o;
  assign in_stall_o = (state_q != ST_IDLE);

  assign pos_ext   = {{XW{1'b0}}, position_i};
  assign pos_x     = pos_ext[XW-1:0];
  assign used_ext  = {{XW{1'b0}}, used_q};
  assign used_x    = used_ext[XW-1:0];
  assign cap_x     = XW'(Capacity);
  assign wdata_ext = {{DataWidth{1'b0}}, wdata_i};
  assign wdata_dw  = wdata_ext[DataWidth-1:0];
  assign pos_q_ext = {{CW{1'b0}}, pos_q};
  assign used_m1   = used_q - CW'(1);
  assign rdata_ext = {{WordWidth{1'b0}}, mem_rdata_q};
  assign len_ext   = {{LengthWidth{1'b0}}, used_q};

  always_comb begin
    state_d       = state_q;
    used_d        = used_q;
    fill_ptr_d    = fill_ptr_q;
    res_status_d  = res_status_q;
    res_use_mem_d = res_use_mem_q;
    mem_we        = 1'b0;
    mem_re        = 1'b0;
    mem_addr      = fill_ptr_q;
    mem_wdata     = '0;
    out_load      = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          state_d       = ST_RESP;
          res_status_d  = STATUS_OK;
          res_use_mem_d = 1'b0;
          unique case (func_e'(func_i))
            FUNC_GET: begin
              if (pos_x >= used_x || pos_x >= cap_x) begin
                res_status_d = STATUS_RANGE;
              end else begin
                mem_re        = 1'b1;
                mem_addr      = pos_x[AW-1:0];
                res_use_mem_d = 1'b1;
              end
            end
            FUNC_SET: begin
              if (pos_x >= cap_x) begin
                res_status_d = STATUS_FULL;
              end else if (pos_x < used_x) begin
                mem_we    = 1'b1;
                mem_addr  = pos_x[AW-1:0];
                mem_wdata = wdata_dw;
              end else begin
                fill_ptr_d = used_q[AW-1:0];
                state_d    = ST_FILL;
              end
            end
            FUNC_PUSH: begin
              if (used_q >= CW'(Capacity)) begin
                res_status_d = STATUS_FULL;
              end else begin
                mem_we    = 1'b1;
                mem_addr  = used_q[AW-1:0];
                mem_wdata = wdata_dw;
                used_d    = used_q + CW'(1);
              end
            end
            FUNC_POP: begin
              if (used_q == '0) begin
                res_status_d = STATUS_RANGE;
              end else begin
                used_d        = used_m1;
                mem_re        = 1'b1;
                mem_addr      = used_m1[AW-1:0];
                res_use_mem_d = 1'b1;
              end
            end
          endcase
        end
      end
      ST_FILL: begin
        mem_we   = 1'b1;
        mem_addr = fill_ptr_q;
        if (fill_ptr_q == pos_q) begin
          mem_wdata = wdata_q;
          used_d    = pos_q_ext[CW-1:0] + CW'(1);
          state_d   = ST_RESP;
        end else begin
          fill_ptr_d = fill_ptr_q + AW'(1);
        end
      end
      ST_RESP: begin
        if (!out_valid_q || !out_stall_i) begin
          out_load = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      used_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      used_q  <= used_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    fill_ptr_q    <= fill_ptr_d;
    res_status_q  <= res_status_d;
    res_use_mem_q <= res_use_mem_d;
    if (in_acc) begin
      pos_q   <= pos_x[AW-1:0];
      wdata_q <= wdata_dw;
    end
    if (out_load) begin
      status_q <= res_status_q;
      rdata_q  <= res_use_mem_q ? rdata_ext[WordWidth-1:0] : '0;
      length_q <= len_ext[LengthWidth-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      store_q[mem_addr] <= mem_wdata;
    end
    if (mem_re) begin
      mem_rdata_q <= store_q[mem_addr];
    end
  end

  assign out_valid_o = out_valid_q;
  assign status_o    = status_q;
  assign rdata_o     = rdata_q;
  assign length_o    = length_q;

  a_used_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    used_q <= CW'(Capacity))
    else $error("Length exceeds capacity.");

  a_fill_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_FILL) |-> (fill_ptr_q <= pos_q))
    else $error("Fill pointer ran past the target position.");

  a_push_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && func_i == FUNC_PUSH && used_q < CW'(Capacity))
      |=> (used_q == CW'($past(used_q) + CW'(1))))
    else $error("Push did not extend the length by one.");

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> (state_q == ST_RESP || state_q == ST_FILL))
    else $error("Accepted item was not taken into processing.");

endmodule
